// ----- rtl/soe_pkg.sv -----
// shared types and codes for the set operation engine
package soe_pkg;

    localparam int SET_SIZE = 8;
    localparam int CNT_W    = $clog2(SET_SIZE + 1);
    localparam int IDX_W    = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND_A = 2'd1,
        FUNC_APPEND_B = 2'd2,
        FUNC_COMPUTE = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        OP_UNION     = 3'd0,
        OP_INTERSECT = 3'd1,
        OP_A_MINUS_B = 3'd2,
        OP_B_MINUS_A = 3'd3,
        OP_SYMMETRIC = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_ALL   = 2'd0,
        MODE_MINUS = 2'd1,
        MODE_INTER = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic       clear;
        logic       load_a;
        logic       load_b;
        logic       scan;
        logic       sel_b;
        scan_mode_t mode;
        logic       flush;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic flush_done;
    } dp_status_t;

endpackage

// ----- rtl/soe_datapath.sv -----
// list storage, scan counters, compare unit, hold stage and output register
module soe_datapath
    import soe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic signed [DATA_W-1:0] element,
    output dp_status_t               status,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,
    output logic                     m_tlast,
    output logic                     m_empty,
    output logic                     m_ovf
);

    logic signed [DATA_W-1:0] list_a_reg [SET_SIZE];
    logic signed [DATA_W-1:0] list_b_reg [SET_SIZE];
    logic [CNT_W-1:0]         cnt_a_reg;
    logic [CNT_W-1:0]         cnt_b_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [CNT_W-1:0]         j_reg;
    logic                     matched_reg;
    logic                     hold_valid_reg;
    logic signed [DATA_W-1:0] hold_value_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_data_reg;
    logic                     m_last_reg;
    logic                     m_empty_reg;
    logic                     m_ovf_reg;

    logic [CNT_W-1:0]         outer_cnt;
    logic [CNT_W-1:0]         inner_cnt;
    logic signed [DATA_W-1:0] x_val;
    logic signed [DATA_W-1:0] y_val;
    logic                     at_end;
    logic                     eq;
    logic                     inner_empty;
    logic                     j_last;
    logic                     produce;
    logic                     adv_i;
    logic                     out_free;
    logic                     need_slot;
    logic                     step_ok;
    logic                     flush_ok;
    logic                     a_full;
    logic                     b_full;

    assign outer_cnt   = cmd.sel_b ? cnt_b_reg : cnt_a_reg;
    assign inner_cnt   = cmd.sel_b ? cnt_a_reg : cnt_b_reg;
    assign x_val       = cmd.sel_b ? list_b_reg[i_reg[IDX_W-1:0]] : list_a_reg[i_reg[IDX_W-1:0]];
    assign y_val       = cmd.sel_b ? list_a_reg[j_reg[IDX_W-1:0]] : list_b_reg[j_reg[IDX_W-1:0]];
    assign at_end      = (i_reg == outer_cnt);
    assign eq          = (x_val == y_val);
    assign inner_empty = (inner_cnt == '0);
    assign j_last      = ((j_reg + CNT_W'(1)) == inner_cnt);
    assign a_full      = (cnt_a_reg == CNT_W'(SET_SIZE));
    assign b_full      = (cnt_b_reg == CNT_W'(SET_SIZE));

    always_comb
    begin
        produce = 1'b0;
        adv_i   = 1'b1;
        case (cmd.mode)
            MODE_ALL:
            begin
                produce = 1'b1;
                adv_i   = 1'b1;
            end
            MODE_MINUS:
            begin
                if (inner_empty)
                begin
                    produce = 1'b1;
                    adv_i   = 1'b1;
                end
                else
                begin
                    produce = j_last && !(matched_reg || eq);
                    adv_i   = j_last;
                end
            end
            MODE_INTER:
            begin
                if (inner_empty)
                begin
                    produce = 1'b0;
                    adv_i   = 1'b1;
                end
                else
                begin
                    produce = eq;
                    adv_i   = j_last;
                end
            end
            default:
            begin
                produce = 1'b0;
                adv_i   = 1'b1;
            end
        endcase
    end

    assign out_free  = !m_valid_reg || m_tready;
    assign need_slot = produce && hold_valid_reg;
    assign step_ok   = cmd.scan && !at_end && (!need_slot || out_free);
    assign flush_ok  = cmd.flush && out_free;

    assign status.scan_end   = cmd.scan && at_end;
    assign status.flush_done = flush_ok;

    // list contents, undefined until written
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && !a_full)
        begin
            list_a_reg[cnt_a_reg[IDX_W-1:0]] <= element;
        end
        if (cmd.load_b && !b_full)
        begin
            list_b_reg[cnt_b_reg[IDX_W-1:0]] <= element;
        end
    end

    // payload of hold stage and output register
    always_ff @(posedge clk)
    begin
        if (step_ok && produce)
        begin
            hold_value_reg <= x_val;
        end
        if (step_ok && need_slot)
        begin
            m_data_reg  <= hold_value_reg;
            m_last_reg  <= 1'b0;
            m_empty_reg <= 1'b0;
        end
        else if (flush_ok)
        begin
            m_data_reg  <= hold_valid_reg ? hold_value_reg : '0;
            m_last_reg  <= 1'b1;
            m_empty_reg <= !hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            matched_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                cnt_a_reg <= '0;
                cnt_b_reg <= '0;
            end
            if (cmd.load_a)
            begin
                if (a_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_a_reg <= cnt_a_reg + CNT_W'(1);
                end
            end
            if (cmd.load_b)
            begin
                if (b_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_b_reg <= cnt_b_reg + CNT_W'(1);
                end
            end

            if (status.scan_end)
            begin
                i_reg       <= '0;
                j_reg       <= '0;
                matched_reg <= 1'b0;
            end
            else if (step_ok)
            begin
                if (adv_i)
                begin
                    i_reg       <= i_reg + CNT_W'(1);
                    j_reg       <= '0;
                    matched_reg <= 1'b0;
                end
                else
                begin
                    j_reg       <= j_reg + CNT_W'(1);
                    matched_reg <= matched_reg || eq;
                end
            end

            if (step_ok && produce)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (flush_ok)
            begin
                hold_valid_reg <= 1'b0;
            end

            // flag travels with the item so later appends cannot change a waiting item
            if ((step_ok && need_slot) || flush_ok)
            begin
                m_valid_reg <= 1'b1;
                m_ovf_reg   <= ovf_reg;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_empty  = m_empty_reg;
    assign m_ovf    = m_ovf_reg;

endmodule

// ----- rtl/soe_ctrl.sv -----
// controller state machine: item decode and scan phase sequencing
module soe_ctrl
    import soe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [2:0] op,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN1  = 2'd1,
        ST_RUN2  = 2'd2,
        ST_FLUSH = 2'd3
    } state_t;

    state_t     state_reg;
    logic [2:0] op_reg;
    logic       accept;
    logic       two_phase;
    logic       op_known;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign two_phase = (op_reg == OP_UNION) || (op_reg == OP_SYMMETRIC);
    assign op_known  = (op == OP_UNION) || (op == OP_INTERSECT) || (op == OP_A_MINUS_B)
                    || (op == OP_B_MINUS_A) || (op == OP_SYMMETRIC);

    always_comb
    begin
        cmd        = '0;
        cmd.mode   = MODE_MINUS;
        cmd.clear  = accept && (func == FUNC_CLEAR);
        cmd.load_a = accept && (func == FUNC_APPEND_A);
        cmd.load_b = accept && (func == FUNC_APPEND_B);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.scan = 1'b0;
            end
            ST_RUN1:
            begin
                cmd.scan = 1'b1;
                case (op_reg)
                    OP_UNION:
                    begin
                        cmd.mode = MODE_ALL;
                    end
                    OP_INTERSECT:
                    begin
                        cmd.mode = MODE_INTER;
                    end
                    OP_B_MINUS_A:
                    begin
                        cmd.sel_b = 1'b1;
                    end
                    default:
                    begin
                        cmd.mode = MODE_MINUS;
                    end
                endcase
            end
            ST_RUN2:
            begin
                // second half of union and symmetric: B minus A
                cmd.scan  = 1'b1;
                cmd.sel_b = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                cmd.scan = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_UNION;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (func == FUNC_COMPUTE))
                    begin
                        op_reg    <= op;
                        state_reg <= op_known ? ST_RUN1 : ST_FLUSH;
                    end
                end
                ST_RUN1:
                begin
                    if (status.scan_end)
                    begin
                        state_reg <= two_phase ? ST_RUN2 : ST_FLUSH;
                    end
                end
                ST_RUN2:
                begin
                    if (status.scan_end)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    if (status.flush_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/set_operation_engine.sv -----
// top level of the set operation engine: controller plus datapath
// clear and append items may follow back to back
// a compute scans one compare per cycle while no result waits on a stalled output register;
// each phase ends with a scan end step and a flush emits the final item with the last mark
// results leave through a one-deep hold stage and an output register; downstream stalls can hold the scan
// rst_n is asynchronous active low and clears counts, overflow flag and control; list contents stay undefined
module set_operation_engine
    import soe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // element
    input  logic [4:0]        s_tuser,   // func[1:0], op[4:2]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // result_value
    output logic              m_tlast,
    output logic [1:0]        m_tuser    // empty_res[0], overflow[1]
);

    dp_cmd_t                  cmd;
    dp_status_t               status;
    logic signed [DATA_W-1:0] result;
    logic                     empty_res;
    logic                     overflow;

    soe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .func     (s_tuser[1:0]),
        .op       (s_tuser[4:2]),
        .status   (status),
        .cmd      (cmd)
    );

    soe_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .element  (signed'(s_tdata)),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (result),
        .m_tlast  (m_tlast),
        .m_empty  (empty_res),
        .m_ovf    (overflow)
    );

    assign m_tdata = unsigned'(result);
    assign m_tuser = {overflow, empty_res};

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty item without last mark");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("empty item with nonzero value");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[1:0] == FUNC_COMPUTE)) |=> !s_tready)
        else $error("input taken while a compute starts");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_tuser[1]) |-> m_tuser[1])
        else $error("overflow flag dropped");

endmodule
